FILE: sv/assert_macros.svh
// Assertion macros shared by the grouped sum threshold detector RTL.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define GSTD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define GSTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/gstd_pkg.sv
// Package for the grouped sum threshold detector: store geometry, codes, state type
// and the command/status structs between controller and datapath. No dependencies.
package gstd_pkg;

  localparam int KEY_DEPTH = 65536;
  localparam int ADDR_W    = $clog2(KEY_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(KEY_DEPTH - 1);

  localparam int KEY_W   = 16;
  localparam int QTY_W   = 16;
  localparam int TOTAL_W = 32;
  localparam int ENTRY_W = TOTAL_W + 1;

  // Input opcodes.
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result kinds.
  localparam logic KIND_CROSS = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } gstd_state_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic exec;
  } gstd_cmd_t;

  typedef struct packed {
    logic clr_last;
  } gstd_stat_t;

endpackage

FILE: sv/grouped_sum_threshold_detect_core.sv
// Grouped sum threshold detector, top level: controller plus datapath (gstd_pkg).
// The accepting edge registers the transaction and its store read; in the execute
// state the result and out_valid are registered. No new transaction is taken until
// the execute state ends. Reset: after rst_n releases, a clearing sweep writes all
// KEY_DEPTH (65536) store entries, one per cycle; busy stays high until it ends.
// The receiver cannot stall: each result is shown for one cycle under out_valid.

module grouped_sum_threshold_detect_core
  import gstd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Input command channel: a transaction is taken when start is high and busy is low.
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_opcode,
  input  logic [KEY_W-1:0]          in_order_key,
  input  logic signed [QTY_W-1:0]   in_quantity,
  // Threshold register write port.
  input  logic                      cfg_we,
  input  logic signed [TOTAL_W-1:0] cfg_wdata,
  // Result channel: one cycle per result, marked by out_valid.
  output logic                      out_valid,
  output logic                      out_result_kind,
  output logic [KEY_W-1:0]          out_result_key,
  output logic signed [TOTAL_W-1:0] out_group_total,
  output logic                      out_group_qualified
);

  // The controller sequences the clear sweep, transaction acceptance and the
  // execute cycle. The datapath reads the key's entry on acceptance so that the
  // registered store data is ready in the execute cycle, where the saturating
  // add, threshold compare and write back all happen. A following transaction
  // is read only after that write, so the same key back to back needs no
  // forwarding path.
  gstd_cmd_t  cmd;
  gstd_stat_t stat;

  gstd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The threshold register is held in the datapath and may be written at any
  // cycle; the compare uses whatever value is present in the execute cycle.
  gstd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_opcode),
    .in_order_key        (in_order_key),
    .in_quantity         (in_quantity),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_result_kind     (out_result_kind),
    .out_result_key      (out_result_key),
    .out_group_total     (out_group_total),
    .out_group_qualified (out_group_qualified)
  );

endmodule

FILE: sv/gstd_ctrl.sv
// Controller state machine of the grouped sum threshold detector.
// Depends on gstd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gstd_ctrl
  import gstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  gstd_stat_t stat,
  output gstd_cmd_t  cmd,
  output logic       busy
);

  gstd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // The sweep may only hand over to idle; no item can slip in while clearing.
  `GSTD_ASSERT(a_clear_exit, clk, rst_n, (state_r == ST_CLEAR) |=> (state_r == ST_CLEAR || state_r == ST_IDLE), "clear sweep left to a state other than idle")

endmodule

FILE: sv/gstd_dp.sv
// Datapath of the grouped sum threshold detector: the sum/flag store, the clearing
// counter, the threshold register, saturating update and the result register.
// Depends on gstd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gstd_dp
  import gstd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  gstd_cmd_t                 cmd,
  output gstd_stat_t                stat,
  input  logic                      in_opcode,
  input  logic [KEY_W-1:0]          in_order_key,
  input  logic signed [QTY_W-1:0]   in_quantity,
  input  logic                      cfg_we,
  input  logic signed [TOTAL_W-1:0] cfg_wdata,
  output logic                      out_valid,
  output logic                      out_result_kind,
  output logic [KEY_W-1:0]          out_result_key,
  output logic signed [TOTAL_W-1:0] out_group_total,
  output logic                      out_group_qualified
);

  // Each entry holds {qualified flag, running total}.
  logic [ENTRY_W-1:0] mem [KEY_DEPTH];

  logic [ENTRY_W-1:0]        rd_data_r;
  logic [ADDR_W-1:0]         clr_addr_r, clr_addr_nxt;
  logic signed [TOTAL_W-1:0] thr_r;

  logic                      op_r;
  logic [KEY_W-1:0]          key_r;
  logic signed [QTY_W-1:0]   qty_r;
  logic                      in_range_r;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_kind_r;
  logic [KEY_W-1:0]          out_key_r;
  logic signed [TOTAL_W-1:0] out_total_r;
  logic                      out_qual_r;

  logic signed [TOTAL_W-1:0] old_sum;
  logic                      old_flag;
  logic [TOTAL_W:0]          sum_wide;
  logic signed [TOTAL_W-1:0] upd_sum;
  logic                      crossed;
  logic                      emit;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ENTRY_W-1:0]        wr_data;
  logic                      res_kind;
  logic signed [TOTAL_W-1:0] res_total;
  logic                      res_qual;

  assign old_sum  = rd_data_r[TOTAL_W-1:0];
  assign old_flag = rd_data_r[TOTAL_W];

  always_comb begin
    sum_wide = {old_sum[TOTAL_W-1], old_sum}
             + {{(TOTAL_W + 1 - QTY_W){qty_r[QTY_W-1]}}, qty_r};
    if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]) begin
      upd_sum = sum_wide[TOTAL_W] ? {1'b1, {(TOTAL_W - 1){1'b0}}}
                                  : {1'b0, {(TOTAL_W - 1){1'b1}}};
    end else begin
      upd_sum = sum_wide[TOTAL_W-1:0];
    end
  end

  assign crossed = (upd_sum > thr_r) && !old_flag;
  assign emit    = (op_r == OP_QUERY) || (in_range_r && crossed);
  assign wr_en   = cmd.exec && (op_r == OP_ACCUM) && in_range_r;
  assign wr_addr = cmd.clr_en ? clr_addr_r : ADDR_W'(key_r);
  assign wr_data = cmd.clr_en ? '0 : {old_flag | crossed, upd_sum};

  always_comb begin
    if (op_r == OP_QUERY) begin
      res_kind  = KIND_QUERY;
      res_total = in_range_r ? old_sum : '0;
      res_qual  = in_range_r & old_flag;
    end else begin
      res_kind  = KIND_CROSS;
      res_total = upd_sum;
      res_qual  = 1'b1;
    end
  end

  assign clr_addr_nxt  = cmd.clr_en ? clr_addr_r + 1'b1 : clr_addr_r;
  assign out_valid_nxt = cmd.exec && emit;
  assign stat.clr_last = (clr_addr_r == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (cmd.clr_en || wr_en) mem[wr_addr] <= wr_data;
    if (cmd.accept) rd_data_r <= mem[ADDR_W'(in_order_key)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_opcode;
      key_r      <= in_order_key;
      qty_r      <= in_quantity;
      in_range_r <= (32'(in_order_key) < 32'(KEY_DEPTH));
    end
    if (cmd.exec) begin
      out_kind_r  <= res_kind;
      out_key_r   <= key_r;
      out_total_r <= res_total;
      out_qual_r  <= res_qual;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_result_key      = out_key_r;
  assign out_group_total     = out_total_r;
  assign out_group_qualified = out_qual_r;

  `GSTD_ASSERT(a_strobe_after_exec, clk, rst_n, out_valid_r |-> $past(cmd.exec), "result strobe without an executed transaction")
  `GSTD_ASSERT(a_cross_above_thr, clk, rst_n, (out_valid_r && out_kind_r == KIND_CROSS) |-> (out_qual_r && out_total_r > $past(thr_r)), "crossing result not above threshold")
  `GSTD_ASSERT_ALWAYS(a_no_write_clash, clk, !(cmd.clr_en && (cmd.exec || cmd.accept)), "store access while clear sweep runs")

endmodule

FILE: test/grouped_sum_threshold_detect_core_tb.sv
// Self-checking testbench for grouped_sum_threshold_detect_core: directed and random
// accumulate/query transactions, checked against an in-bench group-by-sum predictor.
// Depends on gstd_pkg and the grouped_sum_threshold_detect_core RTL only.

module grouped_sum_threshold_detect_core_tb;
  import gstd_pkg::*;

  localparam int RESET_CYCLES   = 6;
  // A result is taken after the execute state and the result register, so a few extra cycles of
  // quiet are enough to let an accumulate that produces no result finish its write-back.
  localparam int SETTLE_CYCLES  = 6;
  localparam int DRAIN_LIMIT    = 64;
  localparam int MAX_REPORTS    = 10;
  localparam int POOL_SIZE      = 12;
  localparam int PHASE_ITEMS    = 120;
  // The limit covers the clearing sweep over every store entry and the transactions
  // that follow, and leaves several times that span as margin.
  localparam int TIMEOUT_CYCLES = 400_000;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef struct {
    logic                      kind;
    logic [KEY_W-1:0]          key;
    logic signed [TOTAL_W-1:0] total;
    logic                      qualified;
  } group_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_opcode = OP_ACCUM;
  logic [KEY_W-1:0]          in_order_key = '0;
  logic signed [QTY_W-1:0]   in_quantity = '0;
  logic                      cfg_we = 1'b0;
  logic signed [TOTAL_W-1:0] cfg_wdata = '0;
  logic                      out_valid;
  logic                      out_result_kind;
  logic [KEY_W-1:0]          out_result_key;
  logic signed [TOTAL_W-1:0] out_group_total;
  logic                      out_group_qualified;

  // Predictor state: running total and crossed flag per key, and the live threshold.
  // Bit types start at zero, which matches the cleared stores after reset.
  bit signed [TOTAL_W-1:0]   group_totals [KEY_DEPTH];
  bit                        group_crossed [KEY_DEPTH];
  logic signed [TOTAL_W-1:0] crossing_threshold = '0;

  group_result_t pending_results[$];
  int            mismatch_count = 0;

  grouped_sum_threshold_detect_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_order_key        (in_order_key),
    .in_quantity         (in_quantity),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_result_kind     (out_result_kind),
    .out_result_key      (out_result_key),
    .out_group_total     (out_group_total),
    .out_group_qualified (out_group_qualified)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Appends one expected result behind those already waiting.
  function automatic void queue_expected(input group_result_t want);
    pending_results = {pending_results, want};
  endfunction

  // Works out what one accepted transaction does to the stores and which result,
  // if any, it must produce. A query always answers; an accumulate answers only on
  // the first time its key's total rises strictly above the threshold.
  function automatic void predict_group_op(input logic op, input logic [KEY_W-1:0] key,
                                           input logic signed [QTY_W-1:0] qty);
    group_result_t           want;
    logic [TOTAL_W:0]        wide_sum;
    logic signed [TOTAL_W-1:0] updated;
    want.key = key;
    if (op == OP_QUERY) begin
      want.kind      = KIND_QUERY;
      want.total     = (key < KEY_DEPTH) ? group_totals[key] : '0;
      want.qualified = (key < KEY_DEPTH) ? group_crossed[key] : 1'b0;
      queue_expected(want);
    end else if (key < KEY_DEPTH) begin
      // Add in one extra bit; the top two bits then tell which limit, if any, was passed.
      wide_sum = {group_totals[key][TOTAL_W-1], group_totals[key]} +
                 {{(TOTAL_W+1-QTY_W){qty[QTY_W-1]}}, qty};
      case (wide_sum[TOTAL_W:TOTAL_W-1])
        2'b01: begin
          updated = TOTAL_MAX;
        end
        2'b10: begin
          updated = TOTAL_MIN;
        end
        default: begin
          updated = wide_sum[TOTAL_W-1:0];
        end
      endcase
      group_totals[key] = updated;
      if (updated > crossing_threshold && !group_crossed[key]) begin
        group_crossed[key] = 1'b1;
        want.kind          = KIND_CROSS;
        want.total         = updated;
        want.qualified     = 1'b1;
        queue_expected(want);
      end
    end
  endfunction

  function automatic void report_mismatch(input string field, input logic [KEY_W-1:0] key,
                                          input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch: key %0d %s expected %0d got %0d", key, field, want, got);
    end
  endfunction

  // Every result strobe is compared with the oldest expectation. Outputs are sampled
  // at the edge that closes the strobe cycle, before the block updates them.
  always @(posedge clk) begin : result_check
    group_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("mismatch: result for key %0d with nothing expected", out_result_key);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch("result_kind", want.key, want.kind, out_result_kind);
        if (out_result_key !== want.key)
          report_mismatch("result_key", want.key, want.key, out_result_key);
        if (out_group_total !== want.total)
          report_mismatch("group_total", want.key, want.total, out_group_total);
        if (out_group_qualified !== want.qualified)
          report_mismatch("group_qualified", want.key, want.qualified, out_group_qualified);
      end
    end
  end

  // Presents one transaction and holds it until an edge sees start high and busy low.
  // Start is left high on return so that back-to-back calls keep the channel full.
  task automatic issue_group_op(input logic op, input logic [KEY_W-1:0] key,
                                input logic signed [QTY_W-1:0] qty);
    begin
      start        <= 1'b1;
      in_opcode    <= op;
      in_order_key <= key;
      in_quantity  <= qty;
      do @(posedge clk); while (busy !== 1'b0);
      predict_group_op(op, key, qty);
    end
  endtask

  // Brings the block to rest: lowers start, waits for every expected result, and then
  // lets the pipeline finish any accumulate that had nothing to report. Expectations
  // that never arrive are failures and are dropped so later phases stay aligned.
  task automatic settle_block();
    int spins;
    begin
      start <= 1'b0;
      spins = 0;
      while (pending_results.size() != 0 && spins < DRAIN_LIMIT) begin
        @(posedge clk);
        spins++;
      end
      if (pending_results.size() != 0) begin
        mismatch_count += pending_results.size();
        $display("mismatch: %0d expected results never arrived", pending_results.size());
        pending_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  // The threshold is only changed while the block is at rest.
  task automatic write_threshold(input logic signed [TOTAL_W-1:0] value);
    begin
      settle_block();
      cfg_we    <= 1'b1;
      cfg_wdata <= value;
      @(posedge clk);
      cfg_we    <= 1'b0;
      crossing_threshold = value;
    end
  endtask

  // Queries right after the clearing sweep must read zero totals and clear flags,
  // at both ends of the key range; the quantity field of a query is ignored.
  task automatic test_reset_state();
    begin
      issue_group_op(OP_QUERY, 16'h0000, 16'sh0000);
      issue_group_op(OP_QUERY, 16'hFFFF, 16'sh8000);
    end
  endtask

  // With the reset threshold of zero a key is reported once, on the accumulate that
  // takes it above zero; later accumulates to it only move the total.
  task automatic test_first_crossing();
    begin
      issue_group_op(OP_ACCUM, 16'h0001, 16'sh0001);
      issue_group_op(OP_ACCUM, 16'h0001, 16'sh7FFF);
      issue_group_op(OP_QUERY, 16'h0001, 16'sh7FFF);
      issue_group_op(OP_ACCUM, 16'hFFFF, 16'sh7FFF);
      issue_group_op(OP_QUERY, 16'hFFFF, 16'sh0000);
    end
  endtask

  // Totals at or below the threshold stay silent, including one that lands exactly on it.
  task automatic test_below_threshold();
    begin
      issue_group_op(OP_ACCUM, 16'h0002, 16'sh8000);
      issue_group_op(OP_ACCUM, 16'h0002, 16'sh7FFF);
      issue_group_op(OP_ACCUM, 16'h0002, 16'sh0001);
      issue_group_op(OP_QUERY, 16'h0002, 16'sh1234);
    end
  endtask

  // A new threshold applies to later accumulates only, and flags already set stay set.
  task automatic test_threshold_change();
    begin
      write_threshold(32'sd100);
      issue_group_op(OP_ACCUM, 16'h0003, 16'sd100);
      issue_group_op(OP_ACCUM, 16'h0003, 16'sd1);
      write_threshold(-32'sd1000);
      issue_group_op(OP_ACCUM, 16'h0001, 16'sd5);
      issue_group_op(OP_ACCUM, 16'h0004, -16'sd999);
      issue_group_op(OP_QUERY, 16'h0003, 16'sd0);
      issue_group_op(OP_QUERY, 16'h0001, 16'sd0);
    end
  endtask

  // One random phase under a given threshold. Most transactions hit a small pool of
  // keys so totals build up and cross; the rest scatter over the whole key space.
  // Quantities lean positive, with the extremes mixed in. The sender works in bursts
  // of random length separated by random gaps, some bursts running straight on.
  task automatic run_random_phase(input logic signed [TOTAL_W-1:0] threshold,
                                  input int n_items);
    logic [KEY_W-1:0]        key_pool [POOL_SIZE];
    logic                    op;
    logic [KEY_W-1:0]        key;
    logic signed [QTY_W-1:0] qty;
    int                      burst;
    int                      gap;
    int                      sent;
    begin
      write_threshold(threshold);
      foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
      sent = 0;
      while (sent < n_items) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          op  = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_ACCUM;
          key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : KEY_W'($urandom);
          case ($urandom_range(0, 9))
            0: begin
              qty = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            1, 2, 3, 4, 5: begin
              qty = QTY_W'($urandom_range(0, 32767));
            end
            default: begin
              qty = QTY_W'($urandom);
            end
          endcase
          issue_group_op(op, key, qty);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Random phases walk through several thresholds, the signed extremes among them.
  // The stores carry over from phase to phase, so earlier flags and totals matter.
  task automatic test_random_traffic();
    begin
      run_random_phase(32'sd0, PHASE_ITEMS);
      run_random_phase(32'sd40000, PHASE_ITEMS);
      run_random_phase(-32'sd60000, PHASE_ITEMS);
      run_random_phase(TOTAL_W'($urandom), PHASE_ITEMS);
      run_random_phase(TOTAL_MAX, PHASE_ITEMS);
      run_random_phase(TOTAL_MIN, PHASE_ITEMS);
      run_random_phase(TOTAL_W'($urandom_range(0, 200000)), PHASE_ITEMS);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The clearing sweep holds busy high; the first transaction simply waits it out.
    test_reset_state();
    test_first_crossing();
    test_below_threshold();
    test_threshold_change();
    test_random_traffic();
    settle_block();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guards against a hung handshake anywhere in the run.
  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: grouped_sum_threshold_detect_core.f
+incdir+sv
sv/gstd_pkg.sv
sv/gstd_ctrl.sv
sv/gstd_dp.sv
sv/grouped_sum_threshold_detect_core.sv
test/grouped_sum_threshold_detect_core_tb.sv
